### sv/plr_pkg.sv
// Shared types and constants of the parametric line rasterizer.
package plr_pkg;

  // Coordinate width is fixed by the item formats on both channels.
  localparam int COORD_BITS = 12;

  typedef struct packed {
    logic                         req_type;
    logic signed [COORD_BITS-1:0] start_x;
    logic signed [COORD_BITS-1:0] start_y;
    logic signed [COORD_BITS-1:0] end_x;
    logic signed [COORD_BITS-1:0] end_y;
  } plr_in_t;

  typedef struct packed {
    logic signed [COORD_BITS-1:0] pixel_x;
    logic signed [COORD_BITS-1:0] pixel_y;
    logic                         last;
  } plr_out_t;

  // Request codes carried in req_type.
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_STEP = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;   // latch a new segment, clear t, mark the line active
    logic square;    // register dx*dx and dy*dy
    logic sum;       // register the squared length
    logic rsq_init;  // start the bit search, or saturate the step on zero length
    logic rsq_add;   // first partial sum of a trial bit
    logic rsq_chk;   // finish the trial sum, compare, keep or drop the bit
    logic mult;      // register delta * t for both axes
    logic finish;    // round, load the result register, advance t
  } plr_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic active;    // a line is loaded and not yet finished
    logic len_zero;  // squared length is zero
    logic bit_last;  // the search is at bit 0
  } plr_sts_t;

endpackage

### sv/plr_dpath.sv
// Datapath of the line rasterizer: segment registers, reciprocal square root search, interpolation.
module plr_dpath import plr_pkg::*; #(
  parameter int FRAC_BITS = 24
) (
  input  logic     clk,
  input  logic     rst_n,
  input  plr_in_t  in_data,
  input  plr_cmd_t cmd,
  output plr_sts_t sts,
  output plr_out_t out_data
);

  localparam int C    = COORD_BITS;
  localparam int F    = FRAC_BITS;
  localparam int DW   = C + 1;              // delta width
  localparam int LW   = 2 * C + 1;          // squared length width
  localparam int PW   = 2 * F + 2 * C + 3;  // s*s*L width
  localparam int QW   = F + 2 * C + 2;      // s*L width
  localparam int SW   = F + 1;              // step width, Q1.F
  localparam int TW   = F + 2;              // t width, Q2.F
  localparam int BW   = $clog2(F + 1);      // bit index width
  localparam int PRW  = DW + TW + 1;        // delta*t width
  localparam int SUMW = PRW + 1;

  localparam logic [PW-1:0]   LIMIT    = PW'(1) << (2 * F);
  localparam logic [SW-1:0]   STEP_MAX = {SW{1'b1}};
  localparam logic [TW-1:0]   ONE_FX   = TW'(1) << F;
  localparam logic [SUMW-1:0] RND_BIAS = (SUMW'(1) << F) - SUMW'(1);
  localparam logic [BW-1:0]   TOP_BIT  = BW'(F);

  logic signed [C-1:0]   origin_x_r, origin_y_r;
  logic signed [DW-1:0]  delta_x_r, delta_y_r;
  logic [TW-1:0]         t_r;
  logic [SW-1:0]         step_r;
  logic                  active_r;
  logic [2*C-1:0]        sq_x_r, sq_y_r;
  logic [LW-1:0]         len_r;
  logic [PW-1:0]         p_r, cand_r;
  logic [QW-1:0]         q_r;
  logic [SW-1:0]         s_r;
  logic [BW-1:0]         b_r;
  logic signed [PRW-1:0] prod_x_r, prod_y_r;
  plr_out_t              out_r;

  logic signed [2*DW-1:0] sq_x_full, sq_y_full;
  logic [PW-1:0]          len_sh2, q_sh, cand_sum;
  logic [SW-1:0]          s_try;
  logic                   fits;
  logic signed [PRW-1:0]  mul_x, mul_y;
  logic signed [SUMW-1:0] org_x_sh, org_y_sh, sum_x, sum_y, rnd_x, rnd_y;
  logic [TW-1:0]          t_next;
  logic                   fin;

  assign sq_x_full = delta_x_r * delta_x_r;
  assign sq_y_full = delta_y_r * delta_y_r;

  // One trial bit: (s + 2^b)^2 * L = s^2*L + 2^(b+1)*s*L + 2^(2b)*L.
  assign len_sh2  = PW'(len_r) << {b_r, 1'b0};
  assign q_sh     = (PW'(q_r) << 1) << b_r;
  assign cand_sum = cand_r + q_sh;
  assign fits     = (cand_sum <= LIMIT);
  assign s_try    = s_r | (SW'(1) << b_r);

  assign mul_x = delta_x_r * $signed({1'b0, t_r});
  assign mul_y = delta_y_r * $signed({1'b0, t_r});

  // Truncation toward zero of the whole sum: add 2^F-1 when it is negative.
  assign org_x_sh = {{(SUMW-C-F){origin_x_r[C-1]}}, origin_x_r, {F{1'b0}}};
  assign org_y_sh = {{(SUMW-C-F){origin_y_r[C-1]}}, origin_y_r, {F{1'b0}}};
  assign sum_x    = org_x_sh + {prod_x_r[PRW-1], prod_x_r};
  assign sum_y    = org_y_sh + {prod_y_r[PRW-1], prod_y_r};
  assign rnd_x    = sum_x + (sum_x[SUMW-1] ? RND_BIAS : '0);
  assign rnd_y    = sum_y + (sum_y[SUMW-1] ? RND_BIAS : '0);

  assign t_next = t_r + TW'(step_r);
  assign fin    = (t_next > ONE_FX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else if (cmd.capture) begin
      active_r <= 1'b1;
    end else if (cmd.finish && fin) begin
      active_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      origin_x_r <= in_data.start_x;
      origin_y_r <= in_data.start_y;
      delta_x_r  <= {in_data.end_x[C-1], in_data.end_x} -
                    {in_data.start_x[C-1], in_data.start_x};
      delta_y_r  <= {in_data.end_y[C-1], in_data.end_y} -
                    {in_data.start_y[C-1], in_data.start_y};
      t_r        <= '0;
    end
    if (cmd.square) begin
      sq_x_r <= sq_x_full[2*C-1:0];
      sq_y_r <= sq_y_full[2*C-1:0];
    end
    if (cmd.sum) begin
      len_r <= {1'b0, sq_x_r} + {1'b0, sq_y_r};
    end
    if (cmd.rsq_init) begin
      p_r <= '0;
      q_r <= '0;
      s_r <= '0;
      b_r <= TOP_BIT;
      if (len_r == '0) begin
        step_r <= STEP_MAX;
      end
    end
    if (cmd.rsq_add) begin
      cand_r <= p_r + len_sh2;
    end
    if (cmd.rsq_chk) begin
      if (fits) begin
        p_r <= cand_sum;
        q_r <= q_r + (QW'(len_r) << b_r);
        s_r <= s_try;
      end
      if (b_r == '0) begin
        step_r <= fits ? s_try : s_r;
      end else begin
        b_r <= b_r - BW'(1);
      end
    end
    if (cmd.mult) begin
      prod_x_r <= mul_x;
      prod_y_r <= mul_y;
    end
    if (cmd.finish) begin
      out_r.pixel_x <= rnd_x[F+C-1:F];
      out_r.pixel_y <= rnd_y[F+C-1:F];
      out_r.last    <= fin;
      t_r           <= t_next;
    end
  end

  assign sts.active   = active_r;
  assign sts.len_zero = (len_r == '0);
  assign sts.bit_last = (b_r == '0);
  assign out_data     = out_r;

endmodule

### sv/plr_ctrl.sv
// Controller of the line rasterizer: sequencing of loads and steps, result register valid.
module plr_ctrl import plr_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_req_type,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  plr_sts_t sts,
  output plr_cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQR  = 3'd1;
  localparam logic [2:0] S_SUM  = 3'd2;
  localparam logic [2:0] S_INIT = 3'd3;
  localparam logic [2:0] S_RADD = 3'd4;
  localparam logic [2:0] S_RCHK = 3'd5;
  localparam logic [2:0] S_FIN  = 3'd6;
  localparam logic [2:0] S_SPARE = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_req_type == REQ_LOAD) begin
            cmd.capture = 1'b1;
            state_nxt   = S_SQR;
          end else if (sts.active) begin
            cmd.mult  = 1'b1;
            state_nxt = S_FIN;
          end
        end
      end
      S_SQR: begin
        cmd.square = 1'b1;
        state_nxt  = S_SUM;
      end
      S_SUM: begin
        cmd.sum   = 1'b1;
        state_nxt = S_INIT;
      end
      S_INIT: begin
        cmd.rsq_init = 1'b1;
        state_nxt    = sts.len_zero ? S_IDLE : S_RADD;
      end
      S_RADD: begin
        cmd.rsq_add = 1'b1;
        state_nxt   = S_RCHK;
      end
      S_RCHK: begin
        cmd.rsq_chk = 1'b1;
        state_nxt   = sts.bit_last ? S_IDLE : S_RADD;
      end
      S_FIN: begin
        if (!out_valid_r || out_ready) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      S_SPARE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (cmd.finish) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;

endmodule

### sv/parametric_line_rasterizer_unit.sv
// Parametric line rasterizer top level. A load item (req_type 0) latches a
// segment's start point and its deltas, clears the parameter t, and finds the
// step 1/sqrt(dx*dx + dy*dy) in Q1.FRAC_BITS with a bit-by-bit search that
// needs no multiplier: each trial bit, FRAC_BITS down to 0, takes shifts, adds
// and one compare in the RADD and RCHK states. A zero-length segment skips the
// search, and its step saturates so that it yields a single pixel; no item is
// taken while a load is in progress. A step item (req_type 1) registers
// delta * t for both axes in the cycle it is accepted and then, once the
// result register is free, rounds start + delta * t toward zero into it and
// advances t; no new item is taken before that, and the result register lets
// the next item in while a result still waits. The item is flagged last when
// the advanced t exceeds 1.0, after which the line is inactive and further
// step items are absorbed without a result. A new load replaces any active
// line.
module parametric_line_rasterizer_unit import plr_pkg::*; #(
  parameter int FRAC_BITS = 24
) (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  plr_in_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output plr_out_t out_data
);

  plr_cmd_t cmd;
  plr_sts_t sts;

  // Sequencing lives in the controller; all arithmetic is in the datapath.
  plr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_req_type (in_data.req_type),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  plr_dpath #(
    .FRAC_BITS (FRAC_BITS)
  ) u_dpath (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_data  (in_data),
    .cmd      (cmd),
    .sts      (sts),
    .out_data (out_data)
  );

  // The result register is only loaded when it is empty or being drained.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |-> (!out_valid || out_ready))
    else $error("result register overwritten while an item was pending");

  // A step item with no active line is absorbed and the block stays ready.
  a_idle_step: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready && in_data.req_type == REQ_STEP && !sts.active)
      |=> in_ready)
    else $error("step without an active line started work");

  // The line only ends when a result is produced.
  a_end_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(sts.active) |-> $past(cmd.finish))
    else $error("line became inactive without a final pixel");

  // Every finished step shows up as a valid result in the next cycle.
  a_result_shown: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> (out_valid && (out_data.last == !sts.active)))
    else $error("finished step did not present a consistent result");

endmodule
